/* src/ip_pseudo_header_checksum_core_macros.svh */
// ----------------------------------------------------------------------------
// ip_pseudo_header_checksum_core_macros
// Assertion macros for the checksum core; empty bodies under synthesis.
// ----------------------------------------------------------------------------
`ifndef IP_PSEUDO_HEADER_CHECKSUM_CORE_MACROS_SVH
`define IP_PSEUDO_HEADER_CHECKSUM_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define IPC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ipc assertion failed");
`define IPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ipc assertion failed");
`else
`define IPC_ASSERT_IMPL(lbl, ante, cons)
`define IPC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* src/ipc_pkg.sv */
// ----------------------------------------------------------------------------
// ipc_pkg
// Shared types, constants and the end-around-carry adder for the checksum core.
// ----------------------------------------------------------------------------
package ipc_pkg;

  localparam logic [1:0]  MODE_HDR     = 2'd0;
  localparam logic [15:0] MAXP_RESET   = 16'd1500;
  localparam logic [1:0]  MODE_RESET   = 2'd1;
  localparam logic [15:0] SUM_ONES     = 16'hffff;
  localparam logic [15:0] V4_LEN_AT    = 16'd2;
  localparam logic [15:0] V6_LEN_AT    = 16'd4;
  localparam logic [15:0] V4_ADDR_LO   = 16'd12;
  localparam logic [15:0] V4_ADDR_HI   = 16'd20;
  localparam logic [15:0] V6_ADDR_LO   = 16'd8;
  localparam logic [15:0] V6_ADDR_HI   = 16'd40;
  localparam logic [15:0] V6_FIXED_HDR = 16'd40;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic       CFG_IDX_MODE = 1'b0;
  localparam logic       CFG_IDX_MAXP = 1'b1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] max_payload;
  } ipc_cfg_t;

  typedef struct packed {
    logic [15:0] addend;
    logic        first;
    logic        last;
    logic        err;
    logic [15:0] tail;
  } ipc_beat_t;

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

/* src/ip_pseudo_header_checksum_core.sv */
// ----------------------------------------------------------------------------
// ip_pseudo_header_checksum_core
// Streaming Internet checksum with optional IPv4/IPv6 pseudo-header.
//
//   channel  direction  handshake           beat
//   in_      input      in_valid/in_stall   one packet byte plus marks
//   out_     output     out_valid/out_stall checksum and length error
//   cfg_     input      cfg_wr_en           register index and data
//
// One byte per cycle sustained while in_stall is low; the end-around adder in the back part sets it.
// With the queue empty, a last byte is written to a queue slot and its result then to the result register.
// Reset is synchronous; config returns to mode 1, max payload 1500.
// in_stall rises only when the four-entry queue is full; out_stall holds
// the result register and backs the queue up.
// ----------------------------------------------------------------------------
`include "ip_pseudo_header_checksum_core_macros.svh"

module ip_pseudo_header_checksum_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first,
  input  logic        in_last,
  input  logic [7:0]  in_proto,
  input  logic [15:0] in_ipv6_header_len,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_checksum,
  output logic        out_length_error
);
  import ipc_pkg::*;

  ipc_cfg_t  cfg_r;
  ipc_beat_t push_beat, head;
  logic      push_en, q_full, q_empty, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode        <= MODE_RESET;
      cfg_r.max_payload <= MAXP_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_IDX_MODE) cfg_r.mode <= cfg_data[1:0];
      if (cfg_index == CFG_IDX_MAXP) cfg_r.max_payload <= cfg_data;
    end
  end

  ipc_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_first           (in_first),
    .in_last            (in_last),
    .in_proto           (in_proto),
    .in_ipv6_header_len (in_ipv6_header_len),
    .q_full             (q_full),
    .push_en            (push_en),
    .push_beat          (push_beat)
  );

  ipc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push_en),
    .din   (push_beat),
    .full  (q_full),
    .pop   (pop),
    .dout  (head),
    .empty (q_empty)
  );

  ipc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .q_empty          (q_empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_checksum     (out_checksum),
    .out_length_error (out_length_error)
  );

  `IPC_ASSERT_IMPL(a_err_zero, out_valid && out_length_error, out_checksum == 16'd0)
  `IPC_ASSERT_IMPL(a_ok_nonzero, out_valid && !out_length_error, out_checksum != 16'd0)
  `IPC_ASSERT_IMPL(a_hdr_no_err, out_valid && cfg_r.mode == MODE_HDR, !out_length_error)
  `IPC_ASSERT_NEXT(a_full_no_push, q_full && !pop, !q_empty)

endmodule

/* src/ipc_front.sv */
// ----------------------------------------------------------------------------
// ipc_front
// Tracks packet position and header fields, turns each byte into a word addend
// and, on the last byte, the length/protocol tail and the length check.
// ----------------------------------------------------------------------------
module ipc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  ipc_pkg::ipc_cfg_t   cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_data_byte,
  input  logic                in_first,
  input  logic                in_last,
  input  logic [7:0]          in_proto,
  input  logic [15:0]         in_ipv6_header_len,
  input  logic                q_full,
  output logic                push_en,
  output ipc_pkg::ipc_beat_t  push_beat
);
  import ipc_pkg::*;

  logic [15:0] pos_r, pos_nxt, hb_r, hb_nxt, lf_r, lf_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [15:0] pos, hb0, lf0, len_at, addr_lo, addr_hi, upper, a1, a2;
  logic        v6;
  logic [15:0] w_even, w_odd;

  assign in_stall = q_full;
  assign push_en  = in_valid && !q_full;

  always_comb begin
    v6        = cfg.mode[1];
    pos       = in_first ? 16'd0 : pos_r;
    lf0       = in_first ? 16'd0 : lf_r;
    hb0       = in_first ? in_ipv6_header_len : hb_r;
    proto_nxt = in_first ? in_proto : proto_r;
    hb_nxt    = (!v6 && pos == 16'd0) ? {10'd0, in_data_byte[3:0], 2'b00} : hb0;
    len_at    = v6 ? V6_LEN_AT : V4_LEN_AT;
    addr_lo   = v6 ? V6_ADDR_LO : V4_ADDR_LO;
    addr_hi   = v6 ? V6_ADDR_HI : V4_ADDR_HI;
    if (pos == len_at) begin
      lf_nxt = {in_data_byte, lf0[7:0]};
    end else if (pos == len_at + 16'd1) begin
      lf_nxt = {lf0[15:8], in_data_byte};
    end else begin
      lf_nxt = lf0;
    end
    w_even = {in_data_byte, 8'd0};
    w_odd  = {8'd0, in_data_byte};
    a1 = 16'd0;
    a2 = 16'd0;
    if (cfg.mode == MODE_HDR) begin
      if (pos < hb_nxt) a1 = pos[0] ? w_odd : w_even;
    end else begin
      if (pos >= addr_lo && pos < addr_hi) a1 = pos[0] ? w_odd : w_even;
      if (pos >= hb_nxt) a2 = (pos[0] ^ hb_nxt[0]) ? w_odd : w_even;
    end
    upper   = lf_nxt - hb_nxt + (v6 ? V6_FIXED_HDR : 16'd0);
    pos_nxt = (pos == SUM_ONES) ? pos : pos + 16'd1;

    push_beat.addend = oc_add(a1, a2);
    push_beat.first  = in_first;
    push_beat.last   = in_last;
    push_beat.err    = (cfg.mode != MODE_HDR) && (upper > cfg.max_payload);
    push_beat.tail   = (cfg.mode == MODE_HDR) ? 16'd0 : oc_add(upper, {8'd0, proto_nxt});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      hb_r    <= '0;
      lf_r    <= '0;
      proto_r <= '0;
    end else if (push_en) begin
      pos_r   <= pos_nxt;
      hb_r    <= hb_nxt;
      lf_r    <= lf_nxt;
      proto_r <= proto_nxt;
    end
  end

endmodule

/* src/ipc_queue.sv */
// ----------------------------------------------------------------------------
// ipc_queue
// Short first-in first-out buffer of classified beats between front and back.
// ----------------------------------------------------------------------------
module ipc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ipc_pkg::ipc_beat_t  din,
  output logic                full,
  input  logic                pop,
  output ipc_pkg::ipc_beat_t  dout,
  output logic                empty
);
  import ipc_pkg::*;

  ipc_beat_t        slot_r [QDEPTH];
  logic [QAW-1:0]   wr_r, rd_r;
  logic [QAW:0]     cnt_r, cnt_nxt;

  assign full  = (cnt_r == QAW'(0) + (QAW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = slot_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + (QAW+1)'(1);
    else if (pop && !push) cnt_nxt = cnt_r - (QAW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + QAW'(1);
      if (pop)  rd_r <= rd_r + QAW'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* src/ipc_back.sv */
// ----------------------------------------------------------------------------
// ipc_back
// Ones'-complement accumulator and result register.
// ----------------------------------------------------------------------------
module ipc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ipc_pkg::ipc_beat_t  head,
  input  logic                q_empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         out_checksum,
  output logic                out_length_error
);
  import ipc_pkg::*;

  logic [15:0] sum_r, sum_nxt, fin;
  logic        ov_r;
  logic [15:0] ck_r;
  logic        err_r;

  assign pop = !q_empty && (!head.last || !ov_r || !out_stall);
  assign out_valid        = ov_r;
  assign out_checksum     = ck_r;
  assign out_length_error = err_r;

  always_comb begin
    sum_nxt = oc_add(head.first ? 16'd0 : sum_r, head.addend);
    fin     = oc_add(sum_nxt, head.tail);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      if (pop) sum_r <= sum_nxt;
      if (pop && head.last) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      err_r <= head.err;
      if (head.err) ck_r <= 16'd0;
      else ck_r <= (fin == 16'd0) ? SUM_ONES : fin;
    end
  end

endmodule

/* dv/ip_pseudo_header_checksum_core_tb.sv */
// ----------------------------------------------------------------------------
// ip_pseudo_header_checksum_core_tb
// Self-checking bench for the streaming checksum core. Packet bytes are fed
// from a queue of pending beats. Each accepted beat runs through a local
// predictor of the ones'-complement sum, the pseudo-header and the length
// check. Results are compared in order against the predicted checksums.
// Directed packets come first, then random phases under varied register
// settings, then an IPv4 and an IPv6 packet. Both channels idle at random.
// ----------------------------------------------------------------------------
module ip_pseudo_header_checksum_core_tb;
  import ipc_pkg::*;

  localparam logic [1:0] MODE_V4_UP    = 2'd1;
  localparam logic [1:0] MODE_V6_UP    = 2'd2;
  localparam logic [1:0] MODE_V6_ALIAS = 2'd3;
  localparam int ITEM_TARGET  = 850;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 4000;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first;
    logic        last;
    logic [7:0]  proto;
    logic [15:0] v6_len;
  } byte_beat_t;

  typedef struct packed {
    logic [15:0] checksum;
    logic        length_error;
  } sum_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_first = 1'b0;
  logic        in_last = 1'b0;
  logic [7:0]  in_proto = 8'd0;
  logic [15:0] in_ipv6_header_len = 16'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_checksum;
  logic        out_length_error;

  ip_pseudo_header_checksum_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_first           (in_first),
    .in_last            (in_last),
    .in_proto           (in_proto),
    .in_ipv6_header_len (in_ipv6_header_len),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_checksum       (out_checksum),
    .out_length_error   (out_length_error)
  );

  byte_beat_t  pending_beats[$];
  sum_result_t expected_sums[$];
  int          items_made = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          src_gap = 0;
  int          snk_left = 0;
  bit          src_idle_on = 1'b0;
  bit          snk_idle_on = 1'b0;

  // predictor state, mirrors the core's registers
  logic [1:0]  cur_mode = MODE_RESET;
  logic [15:0] cur_max = MAXP_RESET;
  logic [15:0] acc_sum = 16'd0;
  logic [15:0] pos = 16'd0;
  logic [15:0] hdr_len = 16'd0;
  logic [15:0] len_fld = 16'd0;
  logic [7:0]  proto_q = 8'd0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] ones_sum(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[15:0] + {15'd0, t[16]};
  endfunction

  function automatic int pick_gap(input bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic add_byte(input logic [7:0] b, input logic odd);
    acc_sum = ones_sum(acc_sum, odd ? {8'd0, b} : {b, 8'd0});
  endtask

  task automatic predict_beat(input byte_beat_t bt);
    logic        v6;
    logic [15:0] p, len_at, lo, hi, rel, upper, s;
    sum_result_t r;
    v6 = cur_mode[1];
    if (bt.first) begin
      acc_sum = 16'd0;
      pos = 16'd0;
      len_fld = 16'd0;
      proto_q = bt.proto;
      hdr_len = bt.v6_len;
    end
    p = pos;
    if (!v6 && p == 16'd0) hdr_len = {10'd0, bt.data_byte[3:0], 2'b00};
    len_at = v6 ? V6_LEN_AT : V4_LEN_AT;
    if (p == len_at) len_fld[15:8] = bt.data_byte;
    else if (p == len_at + 16'd1) len_fld[7:0] = bt.data_byte;
    if (cur_mode == MODE_HDR) begin
      if (p < hdr_len) add_byte(bt.data_byte, p[0]);
    end else begin
      lo = v6 ? V6_ADDR_LO : V4_ADDR_LO;
      hi = v6 ? V6_ADDR_HI : V4_ADDR_HI;
      if (p >= lo && p < hi) add_byte(bt.data_byte, p[0]);
      rel = p - hdr_len;
      if (p >= hdr_len) add_byte(bt.data_byte, rel[0]);
    end
    if (pos != SUM_ONES) pos = pos + 16'd1;
    if (bt.last) begin
      r.length_error = 1'b0;
      if (cur_mode == MODE_HDR) begin
        r.checksum = (acc_sum == 16'd0) ? SUM_ONES : acc_sum;
      end else begin
        upper = v6 ? len_fld - (hdr_len - V6_FIXED_HDR) : len_fld - hdr_len;
        if (upper > cur_max) begin
          r.checksum = 16'd0;
          r.length_error = 1'b1;
        end else begin
          s = ones_sum(ones_sum(acc_sum, upper), {8'd0, proto_q});
          r.checksum = (s == 16'd0) ? SUM_ONES : s;
        end
      end
      expected_sums.push_back(r);
    end
  endtask

  // source side
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_valid && !in_stall)
        predict_beat({in_data_byte, in_first, in_last, in_proto, in_ipv6_header_len});
      if (in_valid && in_stall) begin
      end else if (src_gap != 0) begin
        in_valid <= 1'b0;
        src_gap--;
      end else if (pending_beats.size() != 0) begin
        byte_beat_t nb;
        nb = pending_beats.pop_front();
        in_data_byte       <= nb.data_byte;
        in_first           <= nb.first;
        in_last            <= nb.last;
        in_proto           <= nb.proto;
        in_ipv6_header_len <= nb.v6_len;
        in_valid           <= 1'b1;
        src_gap = pick_gap(src_idle_on);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic flag_mismatch(input string what, input sum_result_t want);
    mismatches++;
    if (mismatches <= 10)
      $display("MISMATCH %s: expected sum %h err %b, got sum %h err %b", what,
               want.checksum, want.length_error, out_checksum, out_length_error);
  endtask

  // result side, back-pressure and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_sums.size() == 0) begin
          flag_mismatch("unexpected beat", '0);
        end else begin
          sum_result_t want;
          want = expected_sums.pop_front();
          if (want.checksum !== out_checksum || want.length_error !== out_length_error)
            flag_mismatch("result", want);
        end
      end
      if (snk_left != 0) begin
        out_stall <= 1'b1;
        snk_left--;
      end else begin
        out_stall <= 1'b0;
        snk_left = pick_gap(snk_idle_on);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("ip_pseudo_header_checksum_core_tb: errors");
        $finish;
      end
    end
  end

  task automatic queue_beat(input byte_beat_t b);
    pending_beats.push_back(b);
    items_made++;
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_IDX_MODE) cur_mode = val[1:0];
    else cur_max = val;
  endtask

  task automatic drain;
    while (pending_beats.size() != 0 || in_valid || expected_sums.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic noise_burst(input int n);
    byte_beat_t b;
    repeat (n) begin
      b = {8'($urandom), 1'($urandom_range(0, 3) == 0), 1'($urandom_range(0, 3) == 0),
           8'($urandom), 16'($urandom)};
      queue_beat(b);
    end
  endtask

  // packet for the given mode, random content, sometimes malformed or unterminated
  task automatic gen_packet(input logic [1:0] m, input bit terminate);
    logic        v6;
    int          hdr, pay, total, k, len_at;
    logic [3:0]  ihl;
    logic [15:0] claim, upper_claim;
    logic [7:0]  proto, bt;
    byte_beat_t  b;
    v6 = m[1];
    ihl = 4'd0;
    pay = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 70) : $urandom_range(0, 16);
    if (!v6) begin
      ihl = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 4)) : 4'($urandom_range(5, 15));
      hdr = ihl * 4;
    end else begin
      k = $urandom_range(0, 19);
      if (k < 10) hdr = 40;
      else if (k < 17) hdr = 40 + $urandom_range(1, 24);
      else hdr = 40 + $urandom_range(25, 65495);
    end
    total = (hdr > 200) ? $urandom_range(1, 60) : hdr + pay;
    if ($urandom_range(0, 9) == 0) total = $urandom_range(1, total);
    upper_claim = ($urandom_range(0, 6) == 0) ? 16'($urandom) : 16'(pay);
    claim = v6 ? upper_claim + 16'(hdr - 40) : upper_claim + 16'(hdr);
    len_at = v6 ? 4 : 2;
    proto = 8'($urandom);
    for (k = 0; k < total; k++) begin
      bt = 8'($urandom);
      if (k == 0) begin
        if (!v6) bt = {($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'h4, ihl};
        else if ($urandom_range(0, 4) != 0) bt[7:4] = 4'h6;
      end
      if (k == len_at) bt = claim[15:8];
      if (k == len_at + 1) bt = claim[7:0];
      b.data_byte = bt;
      b.first = (k == 0);
      b.last = terminate && (k == total - 1);
      b.proto = (k == 0) ? proto : 8'($urandom);
      b.v6_len = (k == 0) ? 16'(hdr) : 16'($urandom);
      queue_beat(b);
    end
  endtask

  initial begin
    logic [1:0]  m;
    logic [15:0] mval;
    int          npk, i, sel;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: stray bytes before any first mark
    queue_beat({8'hff, 1'b0, 1'b0, 8'h00, 16'h0000});
    queue_beat({8'h00, 1'b0, 1'b0, 8'hff, 16'hffff});
    // one-byte packet, header length wraps the upper length
    queue_beat({8'hff, 1'b1, 1'b1, 8'hff, 16'hffff});
    // header of one word, shorter than the addresses
    queue_beat({8'h41, 1'b1, 1'b0, 8'h00, 16'd40});
    queue_beat({8'h00, 1'b0, 1'b0, 8'h11, 16'h0000});
    queue_beat({8'h00, 1'b0, 1'b0, 8'h22, 16'h0000});
    queue_beat({8'h08, 1'b0, 1'b0, 8'h33, 16'h0000});
    queue_beat({8'hff, 1'b0, 1'b0, 8'h44, 16'h0000});
    queue_beat({8'h00, 1'b0, 1'b0, 8'h55, 16'h0000});
    queue_beat({8'hff, 1'b0, 1'b0, 8'h66, 16'h0000});
    queue_beat({8'h80, 1'b0, 1'b1, 8'h77, 16'h0000});
    drain();

    // header-only sum that comes out zero
    write_reg(CFG_IDX_MODE, {14'd0, MODE_HDR});
    write_reg(CFG_IDX_MAXP, 16'hffff);
    @(negedge clk);
    queue_beat({8'h40, 1'b1, 1'b0, 8'h06, 16'd40});
    queue_beat({8'h00, 1'b0, 1'b0, 8'h00, 16'd0});
    queue_beat({8'h00, 1'b0, 1'b1, 8'h00, 16'd0});
    drain();

    // alias mode with no payload allowance
    write_reg(CFG_IDX_MODE, {14'd0, MODE_V6_ALIAS});
    write_reg(CFG_IDX_MAXP, 16'd0);
    @(negedge clk);
    gen_packet(MODE_V6_ALIAS, 1'b1);
    drain();

    while (items_made < ITEM_TARGET) begin
      m = 2'($urandom_range(0, 3));
      mval = {14'd0, m};
      if ($urandom_range(0, 3) == 0) mval[15:2] = 14'($urandom);
      write_reg(CFG_IDX_MODE, mval);
      sel = $urandom_range(0, 5);
      case (sel)
        0: write_reg(CFG_IDX_MAXP, 16'd0);
        1: write_reg(CFG_IDX_MAXP, 16'hffff);
        2: write_reg(CFG_IDX_MAXP, MAXP_RESET);
        3: write_reg(CFG_IDX_MAXP, 16'($urandom_range(0, 60)));
        4: write_reg(CFG_IDX_MAXP, 16'($urandom));
        default: begin
        end
      endcase
      @(negedge clk);
      src_idle_on = ($urandom_range(0, 3) != 0);
      snk_idle_on = ($urandom_range(0, 3) != 0);
      npk = $urandom_range(1, 4);
      for (i = 0; i < npk; i++) begin
        if ($urandom_range(0, 99) < 85)
          gen_packet(m, (i != npk - 1) || ($urandom_range(0, 9) != 0));
        else
          noise_burst($urandom_range(1, 6));
      end
      drain();
    end

    // IPv4 upper-layer packet with the widest payload allowance
    write_reg(CFG_IDX_MODE, {14'd0, MODE_V4_UP});
    write_reg(CFG_IDX_MAXP, 16'hffff);
    @(negedge clk);
    src_idle_on = 1'b0;
    snk_idle_on = 1'b1;
    gen_packet(MODE_V4_UP, 1'b1);
    drain();

    // IPv6 sanity packet at the end
    write_reg(CFG_IDX_MODE, {14'd0, MODE_V6_UP});
    @(negedge clk);
    gen_packet(MODE_V6_UP, 1'b1);
    drain();
    repeat (20) @(posedge clk);

    if (mismatches == 0)
      $display("ip_pseudo_header_checksum_core_tb: clean");
    else
      $display("ip_pseudo_header_checksum_core_tb: errors");
    $finish;
  end

endmodule
